@@ rtl/pawu_pkg.sv @@
package pawu_pkg;

	// fixed-point format of gains, error, integral and output
	localparam int FRAC_BITS = 16;

	// field and register widths
	localparam int DATA_W = 32;
	localparam int DT_W   = 21;
	localparam int LIM_W  = 31;
	localparam int ADDR_W = 5;

	// step time is Q0.24 seconds
	localparam int DT_FRAC = 24;

	// derivative: 48-bit signed, split into two 24-bit halves for the multiplier
	localparam int DER_W     = 48;
	localparam int DER_SPLIT = 24;

	// shared multiplier operands and product
	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;

	// gain product accumulator, gain term bound 2^TERM_EXP, output sum width
	localparam int ACC_W    = 80;
	localparam int TERM_EXP = 61;
	localparam int SUM_W    = 64;

	// serial divider: 33-bit error difference scaled by 2^24
	localparam int DIFF_W  = DATA_W + 1;
	localparam int DIV_W   = DIFF_W + DT_FRAC;
	localparam int REM_W   = DT_W + 1;
	localparam int DCNT_W  = $clog2(DIV_W);

	// register indexes
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_KP   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_KI   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_KD   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ILIM = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_OLIM = 3'd4;

endpackage

@@ rtl/pid_anti_windup_step_unit.sv @@
// PID step with conditional-integration anti-windup, signed Q16.16 fixed point.
// Each accepted item (error, Q0.24 step time, clear flag) runs one controller
// step and gives one result: the output clamped to +/- the output limit, and a
// flag set when saturation held the integral back. Work is done by one shared 33x33
// multiplier under a sequencer, so the block takes one item at a time. A held
// integral redoes the integral term with the old integral, a zero step time skips
// the division, and a clear goes straight to the result. The derivative division
// is a restoring divider that makes one quotient bit per cycle over 57 bits. A
// finished result sits in an output register, so the next item is taken while it
// waits. Gains and limits are written over the APB port at byte addresses 0, 4,
// 8, 12 and 16; the user must write them only while the block is idle, as the
// block itself does not enforce this.
module pid_anti_windup_step_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [pawu_pkg::DATA_W-1:0]  error_value,
	input  logic        [pawu_pkg::DT_W-1:0]    step_time,
	input  logic                                clear_state,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [pawu_pkg::DATA_W-1:0]  correction,
	output logic                                integrator_held,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic        [pawu_pkg::ADDR_W-1:0]  paddr,
	input  logic        [pawu_pkg::DATA_W-1:0]  pwdata,
	output logic        [pawu_pkg::DATA_W-1:0]  prdata,
	output logic                                pready
);

	localparam int DATA_W    = pawu_pkg::DATA_W;
	localparam int DT_W      = pawu_pkg::DT_W;
	localparam int LIM_W     = pawu_pkg::LIM_W;
	localparam int MUL_W     = pawu_pkg::MUL_W;
	localparam int PROD_W    = pawu_pkg::PROD_W;
	localparam int ACC_W     = pawu_pkg::ACC_W;
	localparam int SUM_W     = pawu_pkg::SUM_W;
	localparam int DER_W     = pawu_pkg::DER_W;
	localparam int DER_SPLIT = pawu_pkg::DER_SPLIT;
	localparam int DIFF_W    = pawu_pkg::DIFF_W;
	localparam int DIV_W     = pawu_pkg::DIV_W;
	localparam int REM_W     = pawu_pkg::REM_W;
	localparam int DCNT_W    = pawu_pkg::DCNT_W;
	localparam int CAND_W    = DATA_W + 2;

	localparam logic signed [ACC_W-1:0] TERM_HI = ACC_W'(1) <<< pawu_pkg::TERM_EXP;
	localparam logic signed [ACC_W-1:0] TERM_LO = -TERM_HI;
	localparam logic [DIV_W-1:0] DER_LIM = DIV_W'(1) << (DER_W - 1);
	localparam logic signed [DER_W-1:0] DER_MAX = {1'b0, {(DER_W-1){1'b1}}};
	localparam logic signed [DER_W-1:0] DER_MIN = {1'b1, {(DER_W-1){1'b0}}};
	localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DIV_W - 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_EDT,
		S_CAND,
		S_DIV,
		S_DSAT,
		S_MUL_P,
		S_TERM_P,
		S_MUL_DLO,
		S_MUL_DHI,
		S_ACC_D,
		S_TERM_D,
		S_MUL_I,
		S_TERM_I,
		S_MUL_IH,
		S_TERM_IH,
		S_FIN
	} state_t;

	state_t state_q;

	// configuration
	logic signed [DATA_W-1:0] kp_q, ki_q, kd_q;
	logic        [LIM_W-1:0]  ilim_q, olim_q;
	logic [pawu_pkg::REG_IDX_W-1:0] reg_idx;
	logic cfg_wr;

	// controller state
	logic signed [DATA_W-1:0] integral_q, last_err_q;

	// per-item working registers
	logic signed [DATA_W-1:0] e_q;
	logic        [DT_W-1:0]   dt_q;
	logic signed [DATA_W-1:0] cand_q;
	logic                     neg_q;
	logic        [REM_W-1:0]  rem_q;
	logic        [DIV_W-1:0]  quo_q;
	logic        [DCNT_W-1:0] cnt_q;
	logic signed [DER_W-1:0]  deriv_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [SUM_W-1:0]  pd_q, u_q;
	logic                     held_q;

	// result register
	logic signed [DATA_W-1:0] correction_q;
	logic                     held_out_q;
	logic                     out_valid_q;

	// datapath
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [PROD_W-1:0] edt;
	logic signed [CAND_W-1:0] cand_sum, ilim_ext;
	logic signed [DATA_W-1:0] cand_new;
	logic signed [DIFF_W-1:0] diff;
	logic        [DIFF_W-1:0] diff_mag;
	logic        [REM_W-1:0]  trial;
	logic                     trial_ge;
	logic signed [DER_W-1:0]  deriv_new;
	logic signed [ACC_W-1:0]  term_in, term_sh;
	logic signed [SUM_W-1:0]  term_val, u_new, olim_ext, u_clamp;
	logic                     e_pos, e_neg, held_new;
	logic                     out_free;

	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[pawu_pkg::ADDR_W-1:2];
	assign pready  = 1'b1;

	always_comb begin
		case (reg_idx)
			pawu_pkg::REG_KP:   prdata = kp_q;
			pawu_pkg::REG_KI:   prdata = ki_q;
			pawu_pkg::REG_KD:   prdata = kd_q;
			pawu_pkg::REG_ILIM: prdata = DATA_W'(ilim_q);
			pawu_pkg::REG_OLIM: prdata = DATA_W'(olim_q);
			default:            prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q   <= '0;
			ki_q   <= '0;
			kd_q   <= '0;
			ilim_q <= '0;
			olim_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				pawu_pkg::REG_KP:   kp_q   <= pwdata;
				pawu_pkg::REG_KI:   ki_q   <= pwdata;
				pawu_pkg::REG_KD:   kd_q   <= pwdata;
				pawu_pkg::REG_ILIM: ilim_q <= pwdata[LIM_W-1:0];
				pawu_pkg::REG_OLIM: olim_q <= pwdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// shared multiplier operand selection
	always_comb begin
		case (state_q)
			S_MUL_EDT: begin
				mul_a = MUL_W'(e_q);
				mul_b = $signed(MUL_W'(dt_q));
			end
			S_MUL_P: begin
				mul_a = MUL_W'(kp_q);
				mul_b = MUL_W'(e_q);
			end
			S_MUL_DLO: begin
				mul_a = MUL_W'(kd_q);
				mul_b = $signed(MUL_W'(deriv_q[DER_SPLIT-1:0]));
			end
			S_MUL_DHI: begin
				mul_a = MUL_W'(kd_q);
				mul_b = MUL_W'($signed(deriv_q[DER_W-1:DER_SPLIT]));
			end
			S_MUL_I: begin
				mul_a = MUL_W'(ki_q);
				mul_b = MUL_W'(cand_q);
			end
			S_MUL_IH: begin
				mul_a = MUL_W'(ki_q);
				mul_b = MUL_W'(integral_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// candidate integral: floor(e*dt / 2^24) added and clamped to +/- limit
	assign edt      = prod_q >>> pawu_pkg::DT_FRAC;
	assign ilim_ext = $signed(CAND_W'(ilim_q));
	assign cand_sum = CAND_W'(integral_q) + edt[CAND_W-1:0];

	always_comb begin
		if (cand_sum > ilim_ext)
			cand_new = ilim_ext[DATA_W-1:0];
		else if (cand_sum < -ilim_ext)
			cand_new = -ilim_ext[DATA_W-1:0];
		else
			cand_new = cand_sum[DATA_W-1:0];
	end

	// error difference, magnitude taken for the unsigned divider
	assign diff     = DIFF_W'(e_q) - DIFF_W'(last_err_q);
	assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

	assign trial    = {rem_q[REM_W-2:0], quo_q[DIV_W-1]};
	assign trial_ge = trial >= REM_W'(dt_q);

	// quotient sign restored, truncated toward zero, saturated to 48 bits
	always_comb begin
		if (neg_q) begin
			if (quo_q > DER_LIM)
				deriv_new = DER_MIN;
			else
				deriv_new = -$signed(quo_q[DER_W-1:0]);
		end else begin
			if (quo_q >= DER_LIM)
				deriv_new = DER_MAX;
			else
				deriv_new = $signed(quo_q[DER_W-1:0]);
		end
	end

	// gain term: floor(product / 2^F) clamped to +/- 2^61
	assign term_in = (state_q == S_TERM_D) ? acc_q : ACC_W'(prod_q);
	assign term_sh = term_in >>> pawu_pkg::FRAC_BITS;

	always_comb begin
		if (term_sh > TERM_HI)
			term_val = TERM_HI[SUM_W-1:0];
		else if (term_sh < TERM_LO)
			term_val = TERM_LO[SUM_W-1:0];
		else
			term_val = term_sh[SUM_W-1:0];
	end

	assign u_new    = pd_q + term_val;
	assign olim_ext = $signed(SUM_W'(olim_q));
	assign e_pos    = !e_q[DATA_W-1] && (e_q != '0);
	assign e_neg    = e_q[DATA_W-1];
	assign held_new = ((u_new > olim_ext) && e_pos) || ((u_new < -olim_ext) && e_neg);

	always_comb begin
		if (u_q > olim_ext)
			u_clamp = olim_ext;
		else if (u_q < -olim_ext)
			u_clamp = -olim_ext;
		else
			u_clamp = u_q;
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			integral_q   <= '0;
			last_err_q   <= '0;
			e_q          <= '0;
			dt_q         <= '0;
			cand_q       <= '0;
			neg_q        <= 1'b0;
			rem_q        <= '0;
			quo_q        <= '0;
			cnt_q        <= '0;
			deriv_q      <= '0;
			prod_q       <= '0;
			acc_q        <= '0;
			pd_q         <= '0;
			u_q          <= '0;
			held_q       <= 1'b0;
			correction_q <= '0;
			held_out_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != S_FIN))
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						dt_q <= step_time;
						if (clear_state) begin
							// zero candidate and error so the final step clears the state
							e_q     <= '0;
							cand_q  <= '0;
							u_q     <= '0;
							held_q  <= 1'b0;
							state_q <= S_FIN;
						end else begin
							e_q     <= error_value;
							state_q <= S_MUL_EDT;
						end
					end
				end
				S_MUL_EDT: begin
					prod_q  <= mul_p;
					state_q <= S_CAND;
				end
				S_CAND: begin
					cand_q <= cand_new;
					neg_q  <= diff[DIFF_W-1];
					rem_q  <= '0;
					cnt_q  <= '0;
					if (dt_q == '0) begin
						quo_q   <= '0;
						state_q <= S_DSAT;
					end else begin
						quo_q   <= {diff_mag, {pawu_pkg::DT_FRAC{1'b0}}};
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= trial_ge ? (trial - REM_W'(dt_q)) : trial;
					quo_q <= {quo_q[DIV_W-2:0], trial_ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_LAST)
						state_q <= S_DSAT;
				end
				S_DSAT: begin
					deriv_q <= deriv_new;
					state_q <= S_MUL_P;
				end
				S_MUL_P: begin
					prod_q  <= mul_p;
					state_q <= S_TERM_P;
				end
				S_TERM_P: begin
					pd_q    <= term_val;
					state_q <= S_MUL_DLO;
				end
				S_MUL_DLO: begin
					prod_q  <= mul_p;
					state_q <= S_MUL_DHI;
				end
				S_MUL_DHI: begin
					acc_q   <= ACC_W'(prod_q);
					prod_q  <= mul_p;
					state_q <= S_ACC_D;
				end
				S_ACC_D: begin
					acc_q   <= acc_q + (ACC_W'(prod_q) <<< DER_SPLIT);
					state_q <= S_TERM_D;
				end
				S_TERM_D: begin
					pd_q    <= u_new;
					state_q <= S_MUL_I;
				end
				S_MUL_I: begin
					prod_q  <= mul_p;
					state_q <= S_TERM_I;
				end
				S_TERM_I: begin
					u_q    <= u_new;
					held_q <= held_new;
					// saturating against the error: redo the integral term with the old integral
					if (held_new)
						state_q <= S_MUL_IH;
					else
						state_q <= S_FIN;
				end
				S_MUL_IH: begin
					prod_q  <= mul_p;
					state_q <= S_TERM_IH;
				end
				S_TERM_IH: begin
					u_q     <= u_new;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						correction_q <= u_clamp[DATA_W-1:0];
						held_out_q   <= held_q;
						out_valid_q  <= 1'b1;
						last_err_q   <= e_q;
						if (!held_q)
							integral_q <= cand_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall        = (state_q != S_IDLE);
	assign out_valid       = out_valid_q;
	assign correction      = correction_q;
	assign integrator_held = held_out_q;

endmodule
